### sv/csq_pkg.sv
// Shared types and constants for the circle/square overlap test.
// No dependencies.
package csq_pkg;

  localparam logic KIND_CIRCLE = 1'b0;
  localparam logic KIND_SQUARE = 1'b1;

  // Per-stage control carried along the pipeline with the item
  typedef struct packed {
    logic valid;
    logic both_sq;
    logic sq_hit;
  } csq_flags_t;

endpackage

### sv/csq_prep.sv
// Two pipeline stages: center distances, then axis gaps, bounds and the
// square-square overlap flag. Depends on csq_pkg.
module csq_prep
  import csq_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  adv,
  input  logic                  vld_i,
  input  logic                  k1_i,
  input  logic [COORD_BITS-1:0] x1_i,
  input  logic [COORD_BITS-1:0] y1_i,
  input  logic [COORD_BITS-1:0] s1_i,
  input  logic                  k2_i,
  input  logic [COORD_BITS-1:0] x2_i,
  input  logic [COORD_BITS-1:0] y2_i,
  input  logic [COORD_BITS-1:0] s2_i,
  output csq_flags_t            flags_o,
  output logic [COORD_BITS:0]   a_o,
  output logic [COORD_BITS:0]   b_o,
  output logic [COORD_BITS:0]   bound_o
);

  localparam int N  = COORD_BITS;
  localparam int W1 = COORD_BITS + 1;

  // stage 1
  logic          vld1_r;
  logic          both_sq1_r, both_c1_r;
  logic [N-1:0]  dx_r, dy_r, dx_nxt, dy_nxt;
  logic [W1-1:0] ssum_r, ssum_nxt;
  logic [N-1:0]  rad_r, side_r;

  assign dx_nxt   = (x1_i > x2_i) ? x1_i - x2_i : x2_i - x1_i;
  assign dy_nxt   = (y1_i > y2_i) ? y1_i - y2_i : y2_i - y1_i;
  assign ssum_nxt = W1'(s1_i) + W1'(s2_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else if (adv) begin
      vld1_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      both_sq1_r <= (k1_i == KIND_SQUARE) && (k2_i == KIND_SQUARE);
      both_c1_r  <= (k1_i == KIND_CIRCLE) && (k2_i == KIND_CIRCLE);
      dx_r       <= dx_nxt;
      dy_r       <= dy_nxt;
      ssum_r     <= ssum_nxt;
      rad_r      <= (k1_i == KIND_CIRCLE) ? s1_i : s2_i;
      side_r     <= (k1_i == KIND_CIRCLE) ? s2_i : s1_i;
    end
  end

  // stage 2: doubled units, except for a circle pair
  logic [W1-1:0] dx2, dy2, side_e, gx, gy;
  logic [W1-1:0] a_r, b_r, bound_r, a_nxt, b_nxt, bound_nxt;
  logic          vld2_r, both_sq2_r, sq_hit_r, sq_hit_nxt;

  assign dx2    = {dx_r, 1'b0};
  assign dy2    = {dy_r, 1'b0};
  assign side_e = {1'b0, side_r};
  assign gx     = (dx2 > side_e) ? dx2 - side_e : '0;
  assign gy     = (dy2 > side_e) ? dy2 - side_e : '0;

  assign sq_hit_nxt = (dx2 <= ssum_r) && (dy2 <= ssum_r);
  assign a_nxt      = both_c1_r ? {1'b0, dx_r} : gx;
  assign b_nxt      = both_c1_r ? {1'b0, dy_r} : gy;
  assign bound_nxt  = both_c1_r ? ssum_r : {rad_r, 1'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
    end else if (adv) begin
      vld2_r <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      both_sq2_r <= both_sq1_r;
      sq_hit_r   <= sq_hit_nxt;
      a_r        <= a_nxt;
      b_r        <= b_nxt;
      bound_r    <= bound_nxt;
    end
  end

  assign flags_o = '{valid: vld2_r, both_sq: both_sq2_r, sq_hit: sq_hit_r};
  assign a_o     = a_r;
  assign b_o     = b_r;
  assign bound_o = bound_r;

endmodule

### sv/csq_mult.sv
// Squaring stage: registers the squares of both gaps and of the bound.
// Depends on csq_pkg.
module csq_mult
  import csq_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  csq_flags_t                flags_i,
  input  logic [COORD_BITS:0]       a_i,
  input  logic [COORD_BITS:0]       b_i,
  input  logic [COORD_BITS:0]       bound_i,
  output csq_flags_t                flags_o,
  output logic [2*COORD_BITS+1:0]   a2_o,
  output logic [2*COORD_BITS+1:0]   b2_o,
  output logic [2*COORD_BITS+1:0]   c2_o
);

  localparam int W2 = 2 * (COORD_BITS + 1);

  logic          vld_r, both_sq_r, sq_hit_r;
  logic [W2-1:0] a2_r, b2_r, c2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= flags_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      both_sq_r <= flags_i.both_sq;
      sq_hit_r  <= flags_i.sq_hit;
      a2_r      <= W2'(a_i) * W2'(a_i);
      b2_r      <= W2'(b_i) * W2'(b_i);
      c2_r      <= W2'(bound_i) * W2'(bound_i);
    end
  end

  assign flags_o = '{valid: vld_r, both_sq: both_sq_r, sq_hit: sq_hit_r};
  assign a2_o    = a2_r;
  assign b2_o    = b2_r;
  assign c2_o    = c2_r;

endmodule

### sv/csq_cmp.sv
// Final stage: sum of squares against the squared bound, result register.
// Depends on csq_pkg.
module csq_cmp
  import csq_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  csq_flags_t                flags_i,
  input  logic [2*COORD_BITS+1:0]   a2_i,
  input  logic [2*COORD_BITS+1:0]   b2_i,
  input  logic [2*COORD_BITS+1:0]   c2_i,
  output logic                      vld_o,
  output logic                      hit_o
);

  localparam int W3 = 2 * (COORD_BITS + 1) + 1;

  logic [W3-1:0] sum;
  logic          vld_r, hit_r, hit_nxt;

  assign sum     = W3'(a2_i) + W3'(b2_i);
  assign hit_nxt = flags_i.both_sq ? flags_i.sq_hit : (sum <= W3'(c2_i));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= flags_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r <= hit_nxt;
    end
  end

  assign vld_o = vld_r;
  assign hit_o = hit_r;

endmodule

### sv/circle_square_overlap_test.sv
// Circle/square overlap test, top level. Depends on csq_pkg, csq_prep,
// csq_mult and csq_cmp.
//
// Each item holds two shapes, circle (center, radius) or axis-aligned square
// (center, side); out_hit is 1 when they touch or overlap, edges included.
// One item is accepted per cycle while the pipeline is not stalled, and every
// item gives one result after the input register, two distance/gap stages,
// the squaring stage and the result register. The pipeline moves as a whole:
// it stalls only while a result waits in the output register with out_ready
// low, so in_ready is low only then. The squaring stage, three parallel
// (COORD_BITS+1)-bit squarers, sets the critical path.
module circle_square_overlap_test
  import csq_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_first_kind,
  input  logic [COORD_BITS-1:0] in_first_x,
  input  logic [COORD_BITS-1:0] in_first_y,
  input  logic [COORD_BITS-1:0] in_first_size,
  input  logic                  in_second_kind,
  input  logic [COORD_BITS-1:0] in_second_x,
  input  logic [COORD_BITS-1:0] in_second_y,
  input  logic [COORD_BITS-1:0] in_second_size,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_hit
);

  localparam int N  = COORD_BITS;
  localparam int W1 = COORD_BITS + 1;
  localparam int W2 = 2 * (COORD_BITS + 1);

  logic adv;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  logic         vld_r, k1_r, k2_r;
  logic [N-1:0] x1_r, y1_r, s1_r, x2_r, y2_r, s2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_valid) begin
      k1_r <= in_first_kind;
      x1_r <= in_first_x;
      y1_r <= in_first_y;
      s1_r <= in_first_size;
      k2_r <= in_second_kind;
      x2_r <= in_second_x;
      y2_r <= in_second_y;
      s2_r <= in_second_size;
    end
  end

  csq_flags_t    prep_flags, mult_flags;
  logic [W1-1:0] a, b, bound;
  logic [W2-1:0] a2, b2, c2;

  csq_prep #(.COORD_BITS(COORD_BITS)) u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .vld_i   (vld_r),
    .k1_i    (k1_r),
    .x1_i    (x1_r),
    .y1_i    (y1_r),
    .s1_i    (s1_r),
    .k2_i    (k2_r),
    .x2_i    (x2_r),
    .y2_i    (y2_r),
    .s2_i    (s2_r),
    .flags_o (prep_flags),
    .a_o     (a),
    .b_o     (b),
    .bound_o (bound)
  );

  csq_mult #(.COORD_BITS(COORD_BITS)) u_mult (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .flags_i (prep_flags),
    .a_i     (a),
    .b_i     (b),
    .bound_i (bound),
    .flags_o (mult_flags),
    .a2_o    (a2),
    .b2_o    (b2),
    .c2_o    (c2)
  );

  csq_cmp #(.COORD_BITS(COORD_BITS)) u_cmp (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .flags_i (mult_flags),
    .a2_i    (a2),
    .b2_i    (b2),
    .c2_i    (c2),
    .vld_o   (out_valid),
    .hit_o   (out_hit)
  );

endmodule

### sv/csq_checker.sv
// Port-level checks for circle_square_overlap_test, bound to the top level.
// Depends on nothing but the top level's ports.
module csq_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_hit
);

  // a held result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_hit))
    else $error("result changed while stalled");

  // input side is blocked only by a waiting result
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow output stall");

  // result register loads only on a pipeline advance
  a_rise: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_ready))
    else $error("out_valid rose without an advance");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

endmodule

bind circle_square_overlap_test csq_checker u_csq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_hit   (out_hit)
);

### tb/csq_overlap_checker.sv
// Checker for the circle/square overlap test: watches both channels, predicts
// the hit bit of every accepted item and compares it with the result stream.
// Depends on csq_pkg.
module csq_overlap_checker
  import csq_pkg::*;
#(
  parameter int COORD_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_first_kind,
  input  logic [COORD_BITS-1:0] in_first_x,
  input  logic [COORD_BITS-1:0] in_first_y,
  input  logic [COORD_BITS-1:0] in_first_size,
  input  logic                  in_second_kind,
  input  logic [COORD_BITS-1:0] in_second_x,
  input  logic [COORD_BITS-1:0] in_second_y,
  input  logic [COORD_BITS-1:0] in_second_size,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic                  out_hit,
  output int                    fail_count,
  output int                    pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [63:0] wide_t;

  logic expected_hits[$];
  logic want;

  function automatic wide_t absdiff(wide_t a, wide_t b);
    return (a > b) ? a - b : b - a;
  endfunction

  // doubled distance from a circle center to the square edge on one axis, 0 inside
  function automatic wide_t axis_gap(wide_t c, wide_t s, wide_t side);
    wide_t d2;
    d2 = 2 * absdiff(c, s);
    return (d2 > side) ? d2 - side : 64'd0;
  endfunction

  function automatic logic circle_meets_square(coord_t cx, coord_t cy, coord_t r,
                                               coord_t sx, coord_t sy, coord_t side);
    wide_t r2, gx, gy, ax, ay, sum;
    r2 = 2 * wide_t'(r);
    gx = axis_gap(cx, sx, side);
    gy = axis_gap(cy, sy, side);
    if (gx > r2 || gy > r2) return 1'b0;
    ax = gx * gx;
    ay = gy * gy;
    sum = ax + ay;
    // a sum that wraps is past any squared radius
    if (sum < ax) return 1'b0;
    return sum <= r2 * r2;
  endfunction

  function automatic logic overlap_hit(logic k1, coord_t x1, coord_t y1, coord_t s1,
                                       logic k2, coord_t x2, coord_t y2, coord_t s2);
    wide_t dx, dy, rs;
    dx = absdiff(x1, x2);
    dy = absdiff(y1, y2);
    rs = wide_t'(s1) + wide_t'(s2);
    if (k1 == KIND_CIRCLE && k2 == KIND_CIRCLE) return dx * dx + dy * dy <= rs * rs;
    if (k1 == KIND_SQUARE && k2 == KIND_SQUARE) return (2 * dx <= rs) && (2 * dy <= rs);
    if (k1 == KIND_CIRCLE) return circle_meets_square(x1, y1, s1, x2, y2, s2);
    return circle_meets_square(x2, y2, s2, x1, y1, s1);
  endfunction

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        expected_hits.push_back(overlap_hit(in_first_kind, in_first_x, in_first_y,
                                            in_first_size, in_second_kind, in_second_x,
                                            in_second_y, in_second_size));
      end
      if (out_valid && out_ready) begin
        if (expected_hits.size() == 0) begin
          $error("out_hit: result with no item pending, actual %0d", out_hit);
          fail_count++;
        end else begin
          want = expected_hits.pop_front();
          if (out_hit !== want) begin
            $error("out_hit mismatch: expected %0d, actual %0d", want, out_hit);
            fail_count++;
          end
        end
      end
      pending = expected_hits.size();
    end
  end

endmodule

### tb/tb_circle_square_overlap_test.sv
// Top of the circle/square overlap testbench: clock, reset, shape-pair
// stimulus and verdict. Depends on csq_pkg, circle_square_overlap_test and
// csq_overlap_checker.
module tb_circle_square_overlap_test;
  import csq_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW    = 16;
  localparam int LIMIT = 2000;
  localparam int CMAX  = (1 << CW) - 1;

  typedef logic [CW-1:0] coord_t;
  typedef struct packed {
    logic   kind;
    coord_t x;
    coord_t y;
    coord_t size;
  } shape_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_first_kind = 1'b0;
  coord_t in_first_x = '0;
  coord_t in_first_y = '0;
  coord_t in_first_size = '0;
  logic   in_second_kind = 1'b0;
  coord_t in_second_x = '0;
  coord_t in_second_y = '0;
  coord_t in_second_size = '0;
  logic   out_ready = 1'b0;
  logic   in_ready;
  logic   out_valid;
  logic   out_hit;
  int     fail_count;
  int     pending;
  int     quiet = 0;
  bit     calm = 1'b0;

  always #2 clk = ~clk;

  circle_square_overlap_test #(.COORD_BITS(CW)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_first_kind  (in_first_kind),
    .in_first_x     (in_first_x),
    .in_first_y     (in_first_y),
    .in_first_size  (in_first_size),
    .in_second_kind (in_second_kind),
    .in_second_x    (in_second_x),
    .in_second_y    (in_second_y),
    .in_second_size (in_second_size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit)
  );

  csq_overlap_checker #(.COORD_BITS(CW)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_first_kind  (in_first_kind),
    .in_first_x     (in_first_x),
    .in_first_y     (in_first_y),
    .in_first_size  (in_first_size),
    .in_second_kind (in_second_kind),
    .in_second_x    (in_second_x),
    .in_second_y    (in_second_y),
    .in_second_size (in_second_size),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 35);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic shape_t shape_at(logic k, int x, int y, int s);
    shape_t sh;
    sh.kind = k;
    sh.x = coord_t'(x);
    sh.y = coord_t'(y);
    sh.size = coord_t'(s);
    return sh;
  endfunction

  function automatic coord_t clamp_coord(int v);
    if (v < 0) return '0;
    if (v > CMAX) return coord_t'(CMAX);
    return coord_t'(v);
  endfunction

  // entered and left at a falling edge
  task automatic send_pair(input shape_t a, input shape_t b);
    if (!calm) begin
      while ($urandom_range(99) < 35) begin
        in_valid <= 1'b0;
        @(negedge clk);
      end
    end
    in_valid       <= 1'b1;
    in_first_kind  <= a.kind;
    in_first_x     <= a.x;
    in_first_y     <= a.y;
    in_first_size  <= a.size;
    in_second_kind <= b.kind;
    in_second_x    <= b.x;
    in_second_y    <= b.y;
    in_second_size <= b.size;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  task automatic run_random(input int count);
    shape_t a, b;
    int mode, span, reach;
    for (int n = 0; n < count; n++) begin
      mode = int'($urandom_range(9));
      a = shape_t'($urandom);
      b = shape_t'($urandom);
      a.kind = 1'($urandom_range(1));
      b.kind = 1'($urandom_range(1));
      if (mode < 3) begin
        a.x = coord_t'($urandom);  a.y = coord_t'($urandom);  a.size = coord_t'($urandom);
        b.x = coord_t'($urandom);  b.y = coord_t'($urandom);  b.size = coord_t'($urandom);
      end else if (mode < 9) begin
        // second shape placed near the first: mix of hits and misses
        a.x = coord_t'($urandom);
        a.y = coord_t'($urandom);
        a.size = coord_t'($urandom_range(1) ? $urandom_range(300) : $urandom);
        b.size = coord_t'($urandom_range(1) ? $urandom_range(300) : $urandom);
        span = int'(a.size) + int'(b.size) + 2;
        b.x = clamp_coord(int'(a.x) + int'($urandom_range(2 * span)) - span);
        b.y = clamp_coord(int'(a.y) + int'($urandom_range(2 * span)) - span);
      end else begin
        // on the touching distance (rounded down from a half unit), or one past it
        a.x = coord_t'(2000 + $urandom_range(56000));
        a.y = coord_t'(2000 + $urandom_range(56000));
        a.size = coord_t'($urandom_range(1000));
        b.size = coord_t'($urandom_range(1000));
        if (a.kind == KIND_CIRCLE && b.kind == KIND_CIRCLE)
          reach = int'(a.size) + int'(b.size);
        else if (a.kind == KIND_SQUARE && b.kind == KIND_SQUARE)
          reach = (int'(a.size) + int'(b.size)) / 2;
        else if (a.kind == KIND_CIRCLE)
          reach = (int'(b.size) + 2 * int'(a.size)) / 2;
        else
          reach = (int'(a.size) + 2 * int'(b.size)) / 2;
        reach += int'($urandom_range(1));
        if ($urandom_range(1)) begin
          b.x = coord_t'(int'(a.x) + reach);
          b.y = a.y;
        end else begin
          b.x = a.x;
          b.y = coord_t'(int'(a.y) - reach);
        end
      end
      send_pair(a, b);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero size points, then largest shapes, for every kind pair
    send_pair(shape_at(KIND_CIRCLE, 0, 0, 0), shape_at(KIND_CIRCLE, 0, 0, 0));
    send_pair(shape_at(KIND_CIRCLE, 0, 0, 0), shape_at(KIND_SQUARE, 0, 0, 0));
    send_pair(shape_at(KIND_SQUARE, 0, 0, 0), shape_at(KIND_CIRCLE, 0, 0, 0));
    send_pair(shape_at(KIND_SQUARE, 0, 0, 0), shape_at(KIND_SQUARE, 0, 0, 0));
    send_pair(shape_at(KIND_CIRCLE, CMAX, CMAX, CMAX), shape_at(KIND_CIRCLE, CMAX, CMAX, CMAX));
    send_pair(shape_at(KIND_CIRCLE, CMAX, CMAX, CMAX), shape_at(KIND_SQUARE, CMAX, CMAX, CMAX));
    send_pair(shape_at(KIND_SQUARE, CMAX, CMAX, CMAX), shape_at(KIND_CIRCLE, CMAX, CMAX, CMAX));
    send_pair(shape_at(KIND_SQUARE, CMAX, CMAX, CMAX), shape_at(KIND_SQUARE, CMAX, CMAX, CMAX));
    // opposite corners
    send_pair(shape_at(KIND_CIRCLE, 0, 0, 0), shape_at(KIND_CIRCLE, CMAX, CMAX, 0));
    send_pair(shape_at(KIND_CIRCLE, 0, 0, CMAX), shape_at(KIND_CIRCLE, CMAX, CMAX, CMAX));
    send_pair(shape_at(KIND_SQUARE, 0, 0, CMAX), shape_at(KIND_SQUARE, CMAX, CMAX, CMAX));
    send_pair(shape_at(KIND_SQUARE, 0, 0, CMAX - 1), shape_at(KIND_SQUARE, CMAX, CMAX, CMAX));
    // point on and just off a circle edge
    send_pair(shape_at(KIND_CIRCLE, 100, 100, 5), shape_at(KIND_CIRCLE, 105, 100, 0));
    send_pair(shape_at(KIND_CIRCLE, 100, 100, 5), shape_at(KIND_CIRCLE, 106, 100, 0));
    // odd side lengths
    send_pair(shape_at(KIND_SQUARE, 100, 100, 3), shape_at(KIND_CIRCLE, 101, 100, 0));
    send_pair(shape_at(KIND_CIRCLE, 102, 100, 0), shape_at(KIND_SQUARE, 100, 100, 3));
    send_pair(shape_at(KIND_SQUARE, 100, 100, 3), shape_at(KIND_SQUARE, 102, 100, 1));
    send_pair(shape_at(KIND_SQUARE, 100, 100, 3), shape_at(KIND_SQUARE, 100, 103, 1));
    // circle near a square corner
    send_pair(shape_at(KIND_CIRCLE, 110, 110, 7), shape_at(KIND_SQUARE, 100, 100, 10));
    send_pair(shape_at(KIND_SQUARE, 100, 100, 10), shape_at(KIND_CIRCLE, 110, 110, 8));
    send_pair(shape_at(KIND_CIRCLE, 16'hAAAA, 16'h5555, 16'h00FF),
              shape_at(KIND_SQUARE, 16'h5555, 16'hAAAA, 16'hFF00));

    run_random(250);
    wait_drained();
    calm = 1'b1;
    run_random(150);
    calm = 1'b0;
    run_random(150);
    wait_drained();
    run_random(150);

    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
